// ----- rtl/core/ptqp_pkg.sv -----
// Shared types and constants for the two-bit pixel quantizer and packer.
package ptqp_pkg;

    // Packing geometry
    localparam int CODES_PER_WORD = 8;
    localparam int CODE_W         = 2;
    localparam int WORD_W         = 16;
    localparam int CNT_W          = (CODES_PER_WORD > 1) ? $clog2(CODES_PER_WORD) : 1;

    // Channel and lightness, range, color and configuration widths
    localparam int CHAN_W  = 8;
    localparam int RANGE_W = 7;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 24;

    // Break arithmetic: span times percent, then divide by one hundred
    localparam int PERCENT_DIV = 100;
    localparam int PROD_W      = CHAN_W + RANGE_W;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + PERCENT_DIV - 1) / PERCENT_DIV;
    localparam int RECIP_W     = 13;
    localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

    // Queue depths
    localparam int WORK_DEPTH = 4;
    localparam int RES_DEPTH  = 2;

    // Register reset values
    localparam logic [RANGE_W-1:0] RANGE_RESET  = 7'd50;
    localparam logic [COLOR_W-1:0] TRANSP_RESET = 24'hFF00FF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_RANGE_PERCENT     = 1'b0,
        CFG_TRANSPARENT_COLOR = 1'b1
    } cfg_index_t;

    // Operation codes
    typedef enum logic [0:0] {
        OP_MEASURE = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    // Result kinds
    typedef enum logic [0:0] {
        KIND_WORD   = 1'b0,
        KIND_BREAKS = 1'b1
    } kind_t;

    // Pixel codes
    typedef enum logic [CODE_W-1:0] {
        CODE_DARK   = 2'd0,
        CODE_LIGHT  = 2'd1,
        CODE_TRANSP = 2'd2,
        CODE_MIDDLE = 2'd3
    } code_t;

    // Input item
    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              first;
        logic              last;
    } pixel_t;

    // Result item
    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] packed_word;
        logic [CHAN_W-1:0] low_threshold;
        logic [CHAN_W-1:0] high_threshold;
        logic              final_word;
    } result_t;

    // Classified item between front and back
    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] light;
        logic              transp;
        logic              first;
        logic              last;
    } work_t;

endpackage

// ----- rtl/core/ptqp_front.sv -----
// Front end: accepts pixels, derives lightness and transparency, queues them.
module ptqp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ptqp_pkg::pixel_t              pixel,
    output logic                          full,
    input  logic [ptqp_pkg::COLOR_W-1:0]  transparent_color,
    output logic                          item_valid,
    output ptqp_pkg::work_t               item,
    input  logic                          item_pop
);

    localparam int PTR_W = (ptqp_pkg::WORK_DEPTH > 1) ? $clog2(ptqp_pkg::WORK_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptqp_pkg::WORK_DEPTH + 1);

    ptqp_pkg::work_t            mem_reg [ptqp_pkg::WORK_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [ptqp_pkg::CHAN_W-1:0] hi_chan, lo_chan;
    logic [ptqp_pkg::CHAN_W:0]   light_sum;
    ptqp_pkg::work_t            classified;
    logic                       do_push, do_pop;

    // Take the largest and smallest channel
    always_comb
    begin
        hi_chan = pixel.red;
        lo_chan = pixel.red;
        if (pixel.green > hi_chan) hi_chan = pixel.green;
        if (pixel.blue  > hi_chan) hi_chan = pixel.blue;
        if (pixel.green < lo_chan) lo_chan = pixel.green;
        if (pixel.blue  < lo_chan) lo_chan = pixel.blue;
    end

    // Classify the incoming item
    assign light_sum         = {1'b0, hi_chan} + {1'b0, lo_chan};
    assign classified.op     = pixel.op;
    assign classified.light  = light_sum[ptqp_pkg::CHAN_W:1];
    assign classified.transp = ({pixel.red, pixel.green, pixel.blue} == transparent_color);
    assign classified.first  = pixel.first;
    assign classified.last   = pixel.last;

    // Queue status
    assign full       = (count_reg == CNT_W'(ptqp_pkg::WORK_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ptqp_pkg::WORK_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ptqp_pkg::WORK_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- rtl/core/ptqp_back.sv -----
// Back end: tracks lightness range, derives breaks, codes and packs pixels.
module ptqp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ptqp_pkg::RANGE_W-1:0]  range_percent,
    input  logic                          item_valid,
    input  ptqp_pkg::work_t               item,
    output logic                          item_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output ptqp_pkg::result_t             res_item
);

    localparam int CHAN_W = ptqp_pkg::CHAN_W;
    localparam int CPW    = ptqp_pkg::CODES_PER_WORD;
    localparam int CNT_W  = ptqp_pkg::CNT_W;
    localparam int PROD_W = ptqp_pkg::PROD_W;
    localparam int FULL_W = ptqp_pkg::PROD_W + ptqp_pkg::RECIP_W;
    localparam int QUOT_W = ptqp_pkg::QUOT_W;
    localparam int SUM_W  = QUOT_W + 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t                              state_reg, state_next;
    logic [CHAN_W-1:0]                   min_reg, min_next;
    logic [CHAN_W-1:0]                   max_reg, max_next;
    logic [CHAN_W-1:0]                   low_reg, low_next;
    logic [CHAN_W-1:0]                   high_reg, high_next;
    logic [CHAN_W-1:0]                   mid_reg, mid_next;
    logic [PROD_W-1:0]                   prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]                   prod_hi_reg, prod_hi_next;
    logic [CPW-1:0][ptqp_pkg::CODE_W-1:0] slots_reg, slots_next;
    logic [CNT_W-1:0]                    count_reg, count_next;

    logic                                take;
    ptqp_pkg::code_t                     code;
    logic [CNT_W-1:0]                    idx;
    logic [CPW-1:0][ptqp_pkg::CODE_W-1:0] merged;
    logic                                wrap;
    logic [CHAN_W:0]                     mm_sum;
    logic [CHAN_W-1:0]                   mid_c, dlo, dhi;
    logic [FULL_W-1:0]                   qfull_lo, qfull_hi;
    logic [QUOT_W-1:0]                   q_lo, q_hi;
    logic [SUM_W-1:0]                    low_s, high_s;
    logic [CHAN_W-1:0]                   low_sat, high_sat;

    assign take = (state_reg == ST_RUN) && item_valid && !res_full;
    assign item_pop = take;

    // Code the pixel against the current breaks
    always_comb
    begin
        if (item.transp)
            code = ptqp_pkg::CODE_TRANSP;
        else if (item.light >= high_reg)
            code = ptqp_pkg::CODE_LIGHT;
        else if (item.light <= low_reg)
            code = ptqp_pkg::CODE_DARK;
        else
            code = ptqp_pkg::CODE_MIDDLE;
    end

    // Merge the code into the word; a first pixel drops any partial word
    always_comb
    begin
        idx         = item.first ? '0 : count_reg;
        merged      = item.first ? '0 : slots_reg;
        merged[idx] = code;
        wrap        = (idx == CNT_W'(CPW - 1)) || item.last;
    end

    // Midpoint and the spans from it to the minimum and maximum
    always_comb
    begin
        mm_sum = {1'b0, min_reg} + {1'b0, max_reg};
        mid_c  = mm_sum[CHAN_W:1];
        dlo    = mid_c - min_reg;
        dhi    = max_reg - mid_c;
    end

    // Divide by one hundred through the reciprocal, offset from the midpoint, then saturate
    always_comb
    begin
        qfull_lo = FULL_W'(prod_lo_reg) * FULL_W'(ptqp_pkg::RECIP_MUL);
        qfull_hi = FULL_W'(prod_hi_reg) * FULL_W'(ptqp_pkg::RECIP_MUL);
        q_lo     = qfull_lo[FULL_W-1:ptqp_pkg::RECIP_SHIFT];
        q_hi     = qfull_hi[FULL_W-1:ptqp_pkg::RECIP_SHIFT];
        low_s    = SUM_W'(mid_reg) - SUM_W'(q_lo);
        high_s   = SUM_W'(mid_reg) + SUM_W'(q_hi);
        low_sat  = low_s[SUM_W-1] ? '0 : low_s[CHAN_W-1:0];
        high_sat = (high_s > SUM_W'((1 << CHAN_W) - 1)) ? '1 : high_s[CHAN_W-1:0];
    end

    // Next state and result
    always_comb
    begin
        state_next   = state_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        slots_next   = slots_reg;
        count_next   = count_reg;
        res_push     = 1'b0;
        res_item     = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    if (item.op == ptqp_pkg::OP_MEASURE)
                    begin
                        if (item.first)
                        begin
                            min_next = item.light;
                            max_next = item.light;
                        end
                        else if (!item.transp)
                        begin
                            if (item.light < min_reg) min_next = item.light;
                            if (item.light > max_reg) max_next = item.light;
                        end
                        if (item.last)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        if (wrap)
                        begin
                            res_push                = 1'b1;
                            res_item.kind           = ptqp_pkg::KIND_WORD;
                            res_item.packed_word    = ptqp_pkg::WORD_W'(merged);
                            res_item.final_word     = item.last;
                            slots_next              = '0;
                            count_next              = '0;
                        end
                        else
                        begin
                            slots_next = merged;
                            count_next = idx + 1'b1;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                mid_next     = mid_c;
                prod_lo_next = PROD_W'(dlo) * PROD_W'(range_percent);
                prod_hi_next = PROD_W'(dhi) * PROD_W'(range_percent);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (!res_full)
                begin
                    low_next                = low_sat;
                    high_next               = high_sat;
                    res_push                = 1'b1;
                    res_item.kind           = ptqp_pkg::KIND_BREAKS;
                    res_item.low_threshold  = low_sat;
                    res_item.high_threshold = high_sat;
                    res_item.final_word     = 1'b1;
                    state_next              = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Hold state and arithmetic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            min_reg     <= '0;
            max_reg     <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            mid_reg     <= '0;
            prod_lo_reg <= '0;
            prod_hi_reg <= '0;
            slots_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            mid_reg     <= mid_next;
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            slots_reg   <= slots_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- rtl/core/ptqp_resq.sv -----
// Result queue: holds finished items until the consumer pops them.
module ptqp_resq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  ptqp_pkg::result_t  res_item,
    output logic               res_full,
    output logic               empty,
    input  logic               pop,
    output ptqp_pkg::result_t  result
);

    localparam int PTR_W = (ptqp_pkg::RES_DEPTH > 1) ? $clog2(ptqp_pkg::RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptqp_pkg::RES_DEPTH + 1);

    ptqp_pkg::result_t mem_reg [ptqp_pkg::RES_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign res_full = (count_reg == CNT_W'(ptqp_pkg::RES_DEPTH));
    assign empty    = (count_reg == '0);
    assign result   = mem_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ptqp_pkg::RES_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ptqp_pkg::RES_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

// ----- rtl/core/pixel_two_bit_quantizer_packer_core.sv -----
// Top level of the two-bit pixel quantizer and packer.
//
//   channel   direction  handshake            payload
//   pixel     in         push / full          pixel   (ptqp_pkg::pixel_t)
//   result    out        empty / pop          result  (ptqp_pkg::result_t)
//   config    in         wr_en                wr_index, wr_data
//
// One pixel is accepted per clock while full is low. A word passes through the work
// queue and the result queue before it shows on the result ports; break values
// follow the last measure pixel once the back end has passed its multiply and divide
// states, while the work queue absorbs pixels.
// Async active-low reset clears queues, breaks and word and loads the config reset values.
// Withheld pops stall the back end once the two-entry result queue fills, then full rises.
module pixel_two_bit_quantizer_packer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ptqp_pkg::pixel_t              pixel,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output ptqp_pkg::result_t             result,
    input  logic                          wr_en,
    input  ptqp_pkg::cfg_index_t          wr_index,
    input  logic [ptqp_pkg::CFG_W-1:0]    wr_data
);

    logic [ptqp_pkg::RANGE_W-1:0] range_reg;
    logic [ptqp_pkg::COLOR_W-1:0] transp_reg;
    logic                         item_valid;
    logic                         item_pop;
    ptqp_pkg::work_t              item;
    logic                         res_full;
    logic                         res_push;
    ptqp_pkg::result_t            res_item;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= ptqp_pkg::RANGE_RESET;
            transp_reg <= ptqp_pkg::TRANSP_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ptqp_pkg::CFG_RANGE_PERCENT:
                    range_reg <= wr_data[ptqp_pkg::RANGE_W-1:0];
                ptqp_pkg::CFG_TRANSPARENT_COLOR:
                    transp_reg <= wr_data[ptqp_pkg::COLOR_W-1:0];
                default:
                    range_reg <= range_reg;
            endcase
        end
    end

    // Accept and classify
    ptqp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .pixel             (pixel),
        .full              (full),
        .transparent_color (transp_reg),
        .item_valid        (item_valid),
        .item              (item),
        .item_pop          (item_pop)
    );

    // Measure, code and pack
    ptqp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .range_percent (range_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .res_full      (res_full),
        .res_push      (res_push),
        .res_item      (res_item)
    );

    // Buffer results
    ptqp_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // The back end never pushes into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full queue");

    // The back end only takes items that are waiting
    assert property (@(posedge clk) disable iff (!rst_n) item_pop |-> item_valid)
        else $error("work item popped from empty queue");

    // A pushed result is visible on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) res_push |=> !empty)
        else $error("pushed result not visible");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the two-bit pixel quantizer and packer core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 600000;

    // Predict break values and packed words, and hold the results still due
    class ptqp_scoreboard;
        logic [ptqp_pkg::RANGE_W-1:0] range_pct  = ptqp_pkg::RANGE_RESET;
        logic [ptqp_pkg::COLOR_W-1:0] transp_rgb = ptqp_pkg::TRANSP_RESET;
        logic [ptqp_pkg::CHAN_W-1:0]  min_l      = '0;
        logic [ptqp_pkg::CHAN_W-1:0]  max_l      = '0;
        logic [ptqp_pkg::CHAN_W-1:0]  low_brk    = '0;
        logic [ptqp_pkg::CHAN_W-1:0]  high_brk   = '0;
        logic [ptqp_pkg::WORD_W-1:0]  pack_buf   = '0;
        int                           pack_cnt   = 0;
        ptqp_pkg::result_t            due[$];
        int                           errors     = 0;
        int                           n_pixels   = 0;
        int                           n_words    = 0;
        int                           n_breaks   = 0;

        function void write_reg(ptqp_pkg::cfg_index_t idx, logic [ptqp_pkg::CFG_W-1:0] data);
            case (idx)
                ptqp_pkg::CFG_RANGE_PERCENT:     range_pct = data[ptqp_pkg::RANGE_W-1:0];
                ptqp_pkg::CFG_TRANSPARENT_COLOR: transp_rgb = data[ptqp_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(ptqp_pkg::pixel_t p);
            logic [ptqp_pkg::CHAN_W-1:0] hi;
            logic [ptqp_pkg::CHAN_W-1:0] lo;
            logic [ptqp_pkg::CHAN_W-1:0] light;
            bit                          transp;
            int                          mn;
            int                          mx;
            int                          mid;
            int                          rp;
            int                          lb;
            int                          hb;
            ptqp_pkg::code_t             code;
            ptqp_pkg::result_t           r;
            transp = ({p.red, p.green, p.blue} == transp_rgb);
            hi = p.red;
            lo = p.red;
            if (p.green > hi) hi = p.green;
            if (p.blue > hi) hi = p.blue;
            if (p.green < lo) lo = p.green;
            if (p.blue < lo) lo = p.blue;
            light = 8'((9'(hi) + 9'(lo)) >> 1);
            n_pixels++;
            r = '0;

            // Measure: track the lightness range, derive breaks on the last item
            if (p.op == ptqp_pkg::OP_MEASURE)
            begin
                if (p.first)
                begin
                    min_l = light;
                    max_l = light;
                end
                else if (!transp)
                begin
                    if (light < min_l) min_l = light;
                    if (light > max_l) max_l = light;
                end
                if (!p.last) return;
                mn  = min_l;
                mx  = max_l;
                rp  = range_pct;
                mid = (mn + mx) / 2;
                lb  = mid - ((mid - mn) * rp) / ptqp_pkg::PERCENT_DIV;
                hb  = mid + ((mx - mid) * rp) / ptqp_pkg::PERCENT_DIV;
                low_brk  = (lb < 0) ? 8'd0 : 8'(lb);
                high_brk = (hb > 255) ? 8'd255 : 8'(hb);
                r.kind           = ptqp_pkg::KIND_BREAKS;
                r.low_threshold  = low_brk;
                r.high_threshold = high_brk;
                r.final_word     = 1'b1;
                due.push_back(r);
                return;
            end

            // Convert: classify, then pack with the first item in the low bits
            if (transp) code = ptqp_pkg::CODE_TRANSP;
            else if (light >= high_brk) code = ptqp_pkg::CODE_LIGHT;
            else if (light <= low_brk) code = ptqp_pkg::CODE_DARK;
            else code = ptqp_pkg::CODE_MIDDLE;
            if (p.first)
            begin
                pack_buf = '0;
                pack_cnt = 0;
            end
            pack_buf |= 16'(code) << (ptqp_pkg::CODE_W * pack_cnt);
            pack_cnt++;
            if (pack_cnt >= ptqp_pkg::CODES_PER_WORD || p.last)
            begin
                r.kind        = ptqp_pkg::KIND_WORD;
                r.packed_word = pack_buf;
                r.final_word  = p.last;
                due.push_back(r);
                pack_buf = '0;
                pack_cnt = 0;
            end
        endfunction

        function void check_result(ptqp_pkg::result_t r);
            ptqp_pkg::result_t e;
            if (r.kind == ptqp_pkg::KIND_BREAKS) n_breaks++;
            else n_words++;
            if (due.size() == 0)
            begin
                $error("unexpected result item: kind %0d word %h low %0d high %0d final %0d",
                       r.kind, r.packed_word, r.low_threshold, r.high_threshold,
                       r.final_word);
                errors++;
                return;
            end
            e = due.pop_front();
            if (r.kind !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, r.kind);
                errors++;
            end
            if (r.packed_word !== e.packed_word)
            begin
                $error("packed_word: expected %h, got %h", e.packed_word, r.packed_word);
                errors++;
            end
            if (r.low_threshold !== e.low_threshold)
            begin
                $error("low_threshold: expected %0d, got %0d", e.low_threshold,
                       r.low_threshold);
                errors++;
            end
            if (r.high_threshold !== e.high_threshold)
            begin
                $error("high_threshold: expected %0d, got %0d", e.high_threshold,
                       r.high_threshold);
                errors++;
            end
            if (r.final_word !== e.final_word)
            begin
                $error("final_word: expected %0d, got %0d", e.final_word, r.final_word);
                errors++;
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         push     = 1'b0;
    ptqp_pkg::pixel_t             pixel    = '0;
    logic                         full;
    logic                         empty;
    logic                         pop      = 1'b0;
    ptqp_pkg::result_t            result;
    logic                         wr_en    = 1'b0;
    ptqp_pkg::cfg_index_t         wr_index = ptqp_pkg::CFG_RANGE_PERCENT;
    logic [ptqp_pkg::CFG_W-1:0]   wr_data  = '0;

    ptqp_scoreboard sb = new;

    int sent         = 0;
    int cfg_writes   = 0;
    int stall_cycles = 0;
    int cycles       = 0;
    int tx_calm      = 0;
    int rx_calm      = 0;
    bit rx_hold_req  = 1'b0;
    bit rx_holding   = 1'b0;

    pixel_two_bit_quantizer_packer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pixel    (pixel),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Sample both handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full) sb.note_pixel(pixel);
            if (pop && !empty) sb.check_result(result);
            if (push && full) stall_cycles++;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("run timed out after %0d cycles, %0d results still due", cycles,
                   sb.outstanding());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ptqp_pkg::pixel_t px(ptqp_pkg::op_t op, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, bit fst, bit lst);
        ptqp_pkg::pixel_t p;
        p.op    = op;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.first = fst;
        p.last  = lst;
        return p;
    endfunction

    // Random pixel, biased toward the transparent color, near misses and extremes
    function automatic ptqp_pkg::pixel_t make_pixel(ptqp_pkg::op_t op, bit fst, bit lst);
        ptqp_pkg::pixel_t p;
        int               r;
        r = $urandom_range(0, 99);
        p.op    = op;
        p.first = fst;
        p.last  = lst;
        {p.red, p.green, p.blue} = 24'($urandom);
        if (r < 10)
        begin
            {p.red, p.green, p.blue} = sb.transp_rgb;
        end
        else if (r < 15)
        begin
            {p.red, p.green, p.blue} = sb.transp_rgb ^ (24'd1 << $urandom_range(0, 23));
        end
        else if (r < 30)
        begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // Offer one item, hold it until accepted, then idle at random
    task automatic send_pixel(input ptqp_pkg::pixel_t p);
        int gap;
        pixel <= p;
        push  <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        sent++;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every due result has come out
    task automatic drain();
        push <= 1'b0;
        do @(negedge clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(ptqp_pkg::cfg_index_t idx, logic [ptqp_pkg::CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_writes++;
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One pass of n items; a broken pass scrambles op and the pass markers
    task automatic run_pass(ptqp_pkg::op_t op, int n, bit broken);
        ptqp_pkg::pixel_t p;
        for (int i = 0; i < n; i++)
        begin
            p = make_pixel(op, i == 0, i == n - 1);
            if (broken)
            begin
                p.op    = 1'($urandom_range(0, 1));
                p.first = ($urandom_range(0, 5) == 0);
                p.last  = ($urandom_range(0, 5) == 0);
            end
            send_pixel(p);
        end
    endtask

    // Result side: random pops, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_holding  = 1'b0;
            end
            else
            begin
                gap = pick_gap(rx_calm);
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int                         n;
        int                         k;
        int                         ph;
        logic [ptqp_pkg::CFG_W-1:0] data;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Convert before any measure: both breaks are zero, so black reads light
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));

        // Measure with a transparent seed, extremes, and a skipped transparent item
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'd10, 8'd200, 8'd30, 1'b0, 1'b1));

        // Measure with no first marker keeps growing the current range
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'd128, 8'd128, 8'd128, 1'b0, 1'b1));

        // Convert a full word hitting every code, at and around the breaks
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd64, 8'd64, 8'd64, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd191, 8'd191, 8'd191, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd0, 8'd128, 8'd0, 1'b0, 1'b0));

        // Leave a partial word, then restart: the leftover must be dropped
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd150, 8'd90, 8'd20, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd5, 8'd6, 8'd7, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd250, 8'd240, 8'd230, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1));

        // Range above one hundred saturates both breaks; black is transparent
        drain();
        write_cfg(ptqp_pkg::CFG_RANGE_PERCENT, 24'd127);
        write_cfg(ptqp_pkg::CFG_TRANSPARENT_COLOR, 24'h000000);
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
        send_pixel(px(ptqp_pkg::OP_MEASURE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
        send_pixel(px(ptqp_pkg::OP_CONVERT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));

        // Random images, mostly well formed, with settings changed while idle
        ph = 0;
        while (sent < ITEM_TARGET)
        begin
            ph++;
            if (ph == 6)
            begin
                // Hold the result side off while items keep coming, so input stalls
                drain();
                rx_hold_req = 1'b1;
                wait (rx_holding);
                for (k = 0; k < 40; k++)
                begin
                    send_pixel(make_pixel(ptqp_pkg::OP_CONVERT, 1'b1, 1'b1));
                end
                drain();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       data = 24'd0;
                        1:       data = 24'd100;
                        2:       data = 24'd127;
                        default: data = 24'($urandom_range(0, 127));
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        data = {17'($urandom), data[ptqp_pkg::RANGE_W-1:0]};
                    write_cfg(ptqp_pkg::CFG_RANGE_PERCENT, data);
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       data = 24'h000000;
                        1:       data = 24'hFFFFFF;
                        2:       data = ptqp_pkg::TRANSP_RESET;
                        default: data = 24'($urandom);
                    endcase
                    write_cfg(ptqp_pkg::CFG_TRANSPARENT_COLOR, data);
                end
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 16);
            k = $urandom_range(0, 99);
            if (k < 80)
            begin
                run_pass(ptqp_pkg::OP_MEASURE, n, 1'b0);
                run_pass(ptqp_pkg::OP_CONVERT, $urandom_range(1, 24), 1'b0);
            end
            else if (k < 88)
            begin
                run_pass(ptqp_pkg::OP_CONVERT, n, 1'b0);
            end
            else
            begin
                run_pass(ptqp_pkg::OP_MEASURE, n, 1'b1);
            end
        end

        drain();
        $display("Covered %0d pixels over %0d random rounds with %0d register writes.",
                 sb.n_pixels, ph, cfg_writes);
        $display("Checked %0d packed words and %0d break results; input stalled %0d cycles.",
                 sb.n_words, sb.n_breaks, stall_cycles);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ptqp_pkg.sv
rtl/core/ptqp_front.sv
rtl/core/ptqp_back.sv
rtl/core/ptqp_resq.sv
rtl/core/pixel_two_bit_quantizer_packer_core.sv
tb/tb.sv
